FILE: sv/hrfu_pkg.sv
// ----------------------------------------------------------------------------
// hrfu_pkg
// Shared types and constants of the HEVC RTP payload header builder.
// ----------------------------------------------------------------------------
package hrfu_pkg;

   // configuration register indexes
   localparam logic CSR_PACKET_SIZE = 1'b0;
   localparam logic CSR_HEADER_SIZE = 1'b1;

   localparam logic [15:0] PACKET_SIZE_RESET = 16'd1500;
   localparam logic [7:0]  HEADER_SIZE_RESET = 8'd12;

   // operation codes
   localparam logic OP_FRAME_BYTE = 1'b0;
   localparam logic OP_PACKET_REQ = 1'b1;

   // result kinds
   localparam logic KIND_SCAN   = 1'b0;
   localparam logic KIND_PACKET = 1'b1;

   // scan status codes
   localparam logic [1:0] SCAN_FOUND     = 2'd0;
   localparam logic [1:0] SCAN_NOT_FOUND = 2'd1;
   localparam logic [1:0] SCAN_TOO_SHORT = 2'd2;

   // header length codes
   localparam logic [1:0] HDR_LEN_NONE   = 2'd0;
   localparam logic [1:0] HDR_LEN_SINGLE = 2'd2;
   localparam logic [1:0] HDR_LEN_FU     = 2'd3;

   // payload header constants
   localparam logic [7:0] FU_TYPE_BYTE = 8'h62;   // type 49 shifted into place
   localparam logic [7:0] TYPE_MASK    = 8'h7E;
   localparam logic [7:0] KEEP_MASK    = 8'h81;   // F bit and LayerId msb
   localparam logic [7:0] S_BIT        = 8'h80;
   localparam logic [7:0] E_BIT        = 8'h40;

   localparam int unsigned MIN_FRAME_BYTES = 6;

   typedef struct packed {
      logic        op;
      logic [7:0]  byte_value;
      logic        first_of_frame;
      logic        last_of_frame;
      logic [15:0] payload_len;
   } hrfu_req_type;

   typedef struct packed {
      logic        kind;
      logic [1:0]  scan_status;
      logic [5:0]  nal_type;
      logic [15:0] payload_offset;
      logic [7:0]  header_byte0;
      logic [7:0]  header_byte1;
      logic [7:0]  header_byte2;
      logic [1:0]  header_length;
   } hrfu_rsp_type;

   // scanner match event toward the header builder
   typedef struct packed {
      logic       found;
      logic [7:0] hdr0;
      logic [7:0] hdr1;
   } hrfu_match_type;

endpackage

FILE: sv/hrfu_scan.sv
// ----------------------------------------------------------------------------
// hrfu_scan
// Start code and NAL header search over the frame byte stream.
// ----------------------------------------------------------------------------
module hrfu_scan (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step,
   input  logic [7:0]              byte_value,
   input  logic                    first_of_frame,
   input  logic                    last_of_frame,
   output logic                    result_valid,
   output hrfu_pkg::hrfu_rsp_type  result,
   output hrfu_pkg::hrfu_match_type match
);

   logic [39:0] recent_ff, recent_in;
   logic [15:0] count_ff, count_in;
   logic        done_ff, done_in;

   logic [39:0] recent_base;
   logic [15:0] count_base;
   logic        done_base;
   logic [15:0] count_new;
   logic [5:0]  ty;
   logic        type_ok;
   logic        hit;
   logic        done_after;

   always_comb begin
      recent_base = first_of_frame ? 40'd0 : recent_ff;
      count_base  = first_of_frame ? 16'd0 : count_ff;
      done_base   = first_of_frame ? 1'b0  : done_ff;
      count_new   = (count_base == 16'hFFFF) ? count_base : count_base + 16'd1;
      ty          = 6'((recent_base[7:0] & hrfu_pkg::TYPE_MASK) >> 1);
      type_ok     = (ty < 6'd10) || ((ty > 6'd15) && (ty < 6'd22));
      hit         = !done_base
                    && (count_new >= 16'(hrfu_pkg::MIN_FRAME_BYTES))
                    && (recent_base[39:8] == 32'h0000_0001)
                    && type_ok;
      done_after  = done_base | hit;

      result = '0;
      result.kind = hrfu_pkg::KIND_SCAN;
      result.header_length = hrfu_pkg::HDR_LEN_NONE;
      result_valid = 1'b0;
      if (hit) begin
         result_valid          = 1'b1;
         result.scan_status    = hrfu_pkg::SCAN_FOUND;
         result.nal_type       = ty;
         result.payload_offset = count_new;
         result.header_byte0   = recent_base[7:0];
         result.header_byte1   = byte_value;
      end else if (last_of_frame && !done_after) begin
         result_valid       = 1'b1;
         result.scan_status = (count_new < 16'(hrfu_pkg::MIN_FRAME_BYTES))
                              ? hrfu_pkg::SCAN_TOO_SHORT : hrfu_pkg::SCAN_NOT_FOUND;
      end

      match.found = hit;
      match.hdr0  = recent_base[7:0];
      match.hdr1  = byte_value;

      // clear the scan after the last byte of a frame
      if (last_of_frame) begin
         recent_in = '0;
         count_in  = '0;
         done_in   = 1'b0;
      end else begin
         recent_in = {recent_base[31:0], byte_value};
         count_in  = count_new;
         done_in   = done_after;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         recent_ff <= '0;
         count_ff  <= '0;
         done_ff   <= 1'b0;
      end else if (step) begin
         recent_ff <= recent_in;
         count_ff  <= count_in;
         done_ff   <= done_in;
      end
   end

endmodule

FILE: sv/hrfu_hdr.sv
// ----------------------------------------------------------------------------
// hrfu_hdr
// RTP payload header builder: single NAL or fragmentation unit header.
// ----------------------------------------------------------------------------
module hrfu_hdr (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step,
   input  logic [15:0]             payload_len,
   input  logic [15:0]             packet_size,
   input  logic [7:0]              header_size,
   input  hrfu_pkg::hrfu_match_type match,
   output hrfu_pkg::hrfu_rsp_type  result
);

   logic        pending_ff, pending_in;
   logic [15:0] nal_ff, nal_in;

   logic signed [17:0] lim_single;
   logic signed [17:0] lim_last;
   logic signed [17:0] len_s;
   logic [7:0]         b2;

   always_comb begin
      lim_single = $signed({2'b00, packet_size}) - 18'sd2 - $signed({10'd0, header_size});
      lim_last   = $signed({2'b00, packet_size}) - 18'sd3 - $signed({10'd0, header_size});
      len_s      = $signed({2'b00, payload_len});

      result      = '0;
      result.kind = hrfu_pkg::KIND_PACKET;
      b2          = (nal_ff[7:0] & hrfu_pkg::TYPE_MASK) >> 1;
      if (pending_ff && (len_s <= lim_single)) begin
         result.header_byte0  = nal_ff[7:0];
         result.header_byte1  = nal_ff[15:8];
         result.header_length = hrfu_pkg::HDR_LEN_SINGLE;
      end else begin
         if (pending_ff) begin
            b2 = b2 | hrfu_pkg::S_BIT;
         end else if (len_s <= lim_last) begin
            b2 = b2 | hrfu_pkg::E_BIT;
         end
         result.header_byte0  = (nal_ff[7:0] & hrfu_pkg::KEEP_MASK) | hrfu_pkg::FU_TYPE_BYTE;
         result.header_byte1  = nal_ff[15:8];
         result.header_byte2  = b2;
         result.header_length = hrfu_pkg::HDR_LEN_FU;
      end

      // a request always ends the first-packet phase; a match rearms it
      pending_in = pending_ff;
      nal_in     = nal_ff;
      if (match.found) begin
         pending_in = 1'b1;
         nal_in     = {match.hdr1, match.hdr0};
      end else if (step) begin
         pending_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 1'b0;
         nal_ff     <= '0;
      end else begin
         pending_ff <= pending_in;
         nal_ff     <= nal_in;
      end
   end

endmodule

FILE: sv/hevc_rtp_fu_header_builder.sv
// ----------------------------------------------------------------------------
// hevc_rtp_fu_header_builder
// Start code scanner and RFC 7798 payload header builder in one block.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+---------------------------
//   req     | in        | req_valid/req_stall | hrfu_req_type transaction
//   rsp     | out       | rsp_valid/rsp_stall | hrfu_rsp_type transaction
//   csr     | in        | csr_valid/csr_ready | csr_index, csr_data
//
// One transaction per clock while the result channel does not stall. A request
// is held in the input register, is worked in one pass of scanner or header
// logic, and lands in the result register that drives rsp_valid. Frame bytes that
// produce no result leave no result transaction.
// Synchronous reset clears scan state, first-packet flag, stored NAL header
// and both valid bits, and loads packet_size 1500 and header_size 12.
// A stalled result holds; req_stall rises only when the input register is
// full and the result register cannot drain.
// ----------------------------------------------------------------------------
module hevc_rtp_fu_header_builder (
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   req_valid,
   output logic                   req_stall,
   input  hrfu_pkg::hrfu_req_type req_data,

   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output hrfu_pkg::hrfu_rsp_type rsp_data,

   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic                   csr_index,
   input  logic [15:0]            csr_data
);

   // input register
   logic                   in_valid_ff, in_valid_in;
   hrfu_pkg::hrfu_req_type in_data_ff;

   // result register
   logic                   out_valid_ff, out_valid_in;
   hrfu_pkg::hrfu_rsp_type out_data_ff;

   // configuration
   logic [15:0] packet_size_ff;
   logic [7:0]  header_size_ff;

   logic                    out_free;
   logic                    work;
   logic                    accept;
   logic                    scan_step;
   logic                    hdr_step;
   logic                    scan_valid;
   hrfu_pkg::hrfu_rsp_type  scan_result;
   hrfu_pkg::hrfu_rsp_type  hdr_result;
   hrfu_pkg::hrfu_match_type match;
   hrfu_pkg::hrfu_match_type match_gated;
   logic                    has_result;
   hrfu_pkg::hrfu_rsp_type  next_result;

   // advance the input register whenever the result register can take data
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign work      = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign accept    = req_valid && !req_stall;
   assign scan_step = work && (in_data_ff.op == hrfu_pkg::OP_FRAME_BYTE);
   assign hdr_step  = work && (in_data_ff.op == hrfu_pkg::OP_PACKET_REQ);

   assign csr_ready = 1'b1;

   hrfu_scan u_scan (
      .clock          (clock),
      .reset          (reset),
      .step           (scan_step),
      .byte_value     (in_data_ff.byte_value),
      .first_of_frame (in_data_ff.first_of_frame),
      .last_of_frame  (in_data_ff.last_of_frame),
      .result_valid   (scan_valid),
      .result         (scan_result),
      .match          (match)
   );

   // only a match on a taken frame byte rearms the header builder
   always_comb begin
      match_gated       = match;
      match_gated.found = match.found && scan_step;
   end

   hrfu_hdr u_hdr (
      .clock       (clock),
      .reset       (reset),
      .step        (hdr_step),
      .payload_len (in_data_ff.payload_len),
      .packet_size (packet_size_ff),
      .header_size (header_size_ff),
      .match       (match_gated),
      .result      (hdr_result)
   );

   // select the result of whichever path the transaction took
   always_comb begin
      if (in_data_ff.op == hrfu_pkg::OP_PACKET_REQ) begin
         has_result  = 1'b1;
         next_result = hdr_result;
      end else begin
         has_result  = scan_valid;
         next_result = scan_result;
      end
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (work) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (out_free) begin
         out_valid_in = work && has_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers: load on acceptance / on a produced result
   always_ff @(posedge clock) begin
      if (accept) begin
         in_data_ff <= req_data;
      end
      if (work && has_result) begin
         out_data_ff <= next_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         packet_size_ff <= hrfu_pkg::PACKET_SIZE_RESET;
         header_size_ff <= hrfu_pkg::HEADER_SIZE_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            hrfu_pkg::CSR_PACKET_SIZE: packet_size_ff <= csr_data;
            hrfu_pkg::CSR_HEADER_SIZE: header_size_ff <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

FILE: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the HEVC RTP start code scanner and payload header
// builder. Frame bytes and packet requests go in through the req channel.
// Each accepted transaction is run through a local copy of the scan and
// header logic. Result transactions are compared field by field, in order,
// against the headers and scan reports that this copy says are due.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   typedef logic [7:0] frame_bytes_type [$];

   // clock, reset and block ports; every input starts at a known value
   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   hrfu_pkg::hrfu_req_type req_data  = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   hrfu_pkg::hrfu_rsp_type rsp_data;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic                   csr_index = hrfu_pkg::CSR_PACKET_SIZE;
   logic [15:0]            csr_data  = '0;

   // local copy of the block state: scan window, frame position, match flags,
   // stored NAL header and the two limit registers
   logic [15:0]  cfg_packet_size = hrfu_pkg::PACKET_SIZE_RESET;
   logic [7:0]   cfg_header_size = hrfu_pkg::HEADER_SIZE_RESET;
   logic [39:0]  scan_window     = '0;
   logic [15:0]  scan_count      = '0;
   logic         scan_matched    = 1'b0;
   logic         first_pkt_armed = 1'b0;
   logic [15:0]  stored_nal_hdr  = '0;

   // scan reports and payload headers still owed by the block, oldest first
   hrfu_pkg::hrfu_rsp_type fu_results [$];

   int unsigned  mismatches    = 0;
   int unsigned  items_sent    = 0;
   bit           req_gaps_on   = 1'b1;
   bit           rsp_stalls_on = 1'b1;

   hevc_rtp_fu_header_builder i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #4 clock = ~clock;

   // Stall the result channel in about a quarter of the cycles while enabled.
   always @(negedge clock) begin
      rsp_stall <= rsp_stalls_on && ($urandom_range(99, 0) < 24);
   end

   // Drop everything the scanner knows about the current frame.
   function automatic void restart_frame();
      scan_window  = '0;
      scan_count   = '0;
      scan_matched = 1'b0;
   endfunction

   // Advance the local state by one request transaction; return 1 and fill
   // res when the transaction owes a result.
   function automatic bit build_fu_result(input hrfu_pkg::hrfu_req_type r,
                                          output hrfu_pkg::hrfu_rsp_type res);
      logic [7:0] h0;
      logic [7:0] h1;
      logic [5:0] ty;
      int         lim_single;
      int         lim_last;
      bit         hit;
      res = '0;
      hit = 1'b0;
      if (r.op == hrfu_pkg::OP_FRAME_BYTE) begin
         if (r.first_of_frame) begin
            restart_frame();
         end
         if (scan_count != 16'hFFFF) begin
            scan_count = scan_count + 16'd1;
         end
         // the window holds the five bytes before this one: start code, then
         // the first header byte; this byte completes the header
         if (!scan_matched && scan_count >= hrfu_pkg::MIN_FRAME_BYTES) begin
            h0 = scan_window[7:0];
            ty = h0[6:1];
            if (scan_window[39:8] == 32'h0000_0001 &&
                (ty <= 6'd9 || (ty >= 6'd16 && ty <= 6'd21))) begin
               stored_nal_hdr     = {r.byte_value, h0};
               first_pkt_armed    = 1'b1;
               scan_matched       = 1'b1;
               res.kind           = hrfu_pkg::KIND_SCAN;
               res.scan_status    = hrfu_pkg::SCAN_FOUND;
               res.nal_type       = ty;
               res.payload_offset = scan_count;
               res.header_byte0   = h0;
               res.header_byte1   = r.byte_value;
               res.header_length  = hrfu_pkg::HDR_LEN_NONE;
               hit = 1'b1;
            end
         end
         scan_window = {scan_window[31:0], r.byte_value};
         if (r.last_of_frame) begin
            if (!scan_matched) begin
               res.kind        = hrfu_pkg::KIND_SCAN;
               res.scan_status = (scan_count < hrfu_pkg::MIN_FRAME_BYTES)
                                 ? hrfu_pkg::SCAN_TOO_SHORT : hrfu_pkg::SCAN_NOT_FOUND;
               hit = 1'b1;
            end
            restart_frame();
         end
      end else begin
         // limits are signed: a transport header larger than the packet
         // leaves room for nothing
         lim_single = int'(cfg_packet_size) - 2 - int'(cfg_header_size);
         lim_last   = int'(cfg_packet_size) - 3 - int'(cfg_header_size);
         h0 = stored_nal_hdr[7:0];
         h1 = stored_nal_hdr[15:8];
         res.kind         = hrfu_pkg::KIND_PACKET;
         res.header_byte1 = h1;
         if (first_pkt_armed && int'(r.payload_len) <= lim_single) begin
            first_pkt_armed   = 1'b0;
            res.header_byte0  = h0;
            res.header_length = hrfu_pkg::HDR_LEN_SINGLE;
         end else begin
            res.header_byte0  = (h0 & hrfu_pkg::KEEP_MASK) | hrfu_pkg::FU_TYPE_BYTE;
            res.header_byte2  = {2'b00, h0[6:1]};
            res.header_length = hrfu_pkg::HDR_LEN_FU;
            if (first_pkt_armed) begin
               res.header_byte2 = res.header_byte2 | hrfu_pkg::S_BIT;
               first_pkt_armed  = 1'b0;
            end else if (int'(r.payload_len) <= lim_last) begin
               res.header_byte2 = res.header_byte2 | hrfu_pkg::E_BIT;
            end
         end
         hit = 1'b1;
      end
      return hit;
   endfunction

   // Pick a payload length, mostly right around the single-NAL and last
   // fragment limits, sometimes at the extremes or anywhere.
   function automatic logic [15:0] pick_len();
      int near;
      near = int'(cfg_packet_size) - int'(cfg_header_size) - 4 + int'($urandom_range(5, 0));
      case ($urandom_range(3, 0))
         0: begin
            near = int'($urandom_range(65535, 0));
         end
         1: begin
            near = $urandom_range(1, 0) ? 65535 : 0;
         end
         default: ;
      endcase
      if (near < 0) near = 0;
      if (near > 65535) near = 65535;
      return near[15:0];
   endfunction

   // Present one request transaction, hold it until accepted, then predict.
   task automatic send_item(input hrfu_pkg::hrfu_req_type r);
      hrfu_pkg::hrfu_rsp_type res;
      while (req_gaps_on && $urandom_range(99, 0) < 24) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (build_fu_result(r, res)) begin
         fu_results.push_back(res);
      end
      items_sent++;
      @(negedge clock);
   endtask

   // Send a frame; fields that frame bytes do not use get random values.
   task automatic send_frame(input frame_bytes_type fb, input bit mark_first);
      hrfu_pkg::hrfu_req_type r;
      foreach (fb[i]) begin
         r                = '0;
         r.op             = hrfu_pkg::OP_FRAME_BYTE;
         r.byte_value     = fb[i];
         r.first_of_frame = mark_first && (i == 0);
         r.last_of_frame  = (i == fb.size() - 1);
         r.payload_len    = 16'($urandom_range(65535, 0));
         send_item(r);
      end
   endtask

   // Ask for the next payload header; the frame fields are noise here.
   task automatic send_request(input logic [15:0] len);
      hrfu_pkg::hrfu_req_type r;
      r.op             = hrfu_pkg::OP_PACKET_REQ;
      r.byte_value     = 8'($urandom_range(255, 0));
      r.first_of_frame = 1'($urandom_range(1, 0));
      r.last_of_frame  = 1'($urandom_range(1, 0));
      r.payload_len    = len;
      send_item(r);
   endtask

   // Idle the input, wait for every owed result, then give the pipeline
   // time to swallow bytes that produce nothing.
   task automatic drain();
      req_valid <= 1'b0;
      wait (fu_results.size() == 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_register(input logic idx, input logic [15:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == hrfu_pkg::CSR_PACKET_SIZE) begin
         cfg_packet_size = value;
      end else begin
         cfg_header_size = value[7:0];
      end
      @(negedge clock);
   endtask

   // Write both limits while the block is idle.
   task automatic program_limits(input logic [15:0] pkt, input logic [7:0] hdr);
      drain();
      write_register(hrfu_pkg::CSR_PACKET_SIZE, pkt);
      write_register(hrfu_pkg::CSR_HEADER_SIZE, {8'h00, hdr});
      csr_valid <= 1'b0;
   endtask

   // Requests with nothing matched yet use the zero header: always FU, no S.
   task automatic test_requests_before_match();
      send_request(16'd0);
      send_request(16'hFFFF);
      send_request(16'd1485);
   endtask

   task automatic test_short_frames();
      frame_bytes_type fb;
      fb = {8'h00};
      send_frame(fb, 1'b1);
      fb = {8'h00, 8'h00, 8'h00, 8'h01, 8'h40};
      send_frame(fb, 1'b1);
      // start code and first header byte fit, second header byte is past the end
      fb = {8'h11, 8'h00, 8'h00, 8'h00, 8'h01, 8'h02};
      send_frame(fb, 1'b1);
   endtask

   task automatic test_header_window();
      frame_bytes_type fb;
      // match on the sixth byte; the second start code after it is ignored
      fb = {8'h00, 8'h00, 8'h00, 8'h01, 8'h26, 8'h01,
            8'h00, 8'h00, 8'h00, 8'h01, 8'h02, 8'h01, 8'hAA};
      send_frame(fb, 1'b1);
      // no first_of_frame: the previous last byte already opened a frame;
      // type 10 is outside the accepted ranges
      fb = {8'h5A, 8'h00, 8'h00, 8'h00, 8'h01, 8'h14, 8'h01};
      send_frame(fb, 1'b0);
      fb = {8'h00, 8'h00, 8'h00, 8'h01, 8'h2C, 8'hFF};
      send_frame(fb, 1'b1);
      // type 9, one byte further in
      fb = {8'hFF, 8'h00, 8'h00, 8'h00, 8'h01, 8'h12, 8'h34};
      send_frame(fb, 1'b1);
   endtask

   task automatic test_packet_limits();
      frame_bytes_type fb;
      // default limits: single up to 1486 bytes, last fragment up to 1485
      fb = {8'h00, 8'h00, 8'h00, 8'h01, 8'h02, 8'h01};
      send_frame(fb, 1'b1);
      send_request(16'd1486);
      send_request(16'd1486);
      // type 20 with F and LayerId msb set, so the kept bits show up
      fb = {8'h00, 8'h00, 8'h00, 8'h01, 8'hA9, 8'hFF};
      send_frame(fb, 1'b1);
      send_request(16'd1487);
      send_request(16'd1486);
      send_request(16'd1485);
      send_request(16'd0);
   endtask

   task automatic test_extreme_limits();
      frame_bytes_type fb;
      fb = {8'h00, 8'h00, 8'h00, 8'h01, 8'h20, 8'h81};
      // both limits negative: no length fits a single or a last packet
      program_limits(16'd16, 8'd255);
      send_frame(fb, 1'b1);
      send_request(16'd0);
      send_request(16'd0);
      // largest packet, no transport header
      program_limits(16'hFFFF, 8'd0);
      send_frame(fb, 1'b1);
      send_request(16'd65533);
      send_frame(fb, 1'b1);
      send_request(16'hFFFF);
      send_request(16'd65533);
      send_request(16'd65532);
   endtask

   // Random mix: mostly frames with a planted start code followed by
   // requests, plus stray bytes with random frame marks and lone requests.
   task automatic run_traffic(input int unsigned n);
      int unsigned            stop_at;
      int unsigned            choice;
      int                     len;
      int                     pos;
      logic [5:0]             nal_ty;
      hrfu_pkg::hrfu_req_type r;
      frame_bytes_type        fb;
      stop_at = items_sent + n;
      while (items_sent < stop_at) begin
         choice = $urandom_range(99, 0);
         if (choice < 70) begin
            len = ($urandom_range(9, 0) == 0) ? $urandom_range(5, 1) : $urandom_range(30, 6);
            fb.delete();
            repeat (len) begin
               fb.push_back(($urandom_range(3, 0) == 0) ? 8'h00 : 8'($urandom_range(255, 0)));
            end
            if (len >= 5 && $urandom_range(9, 0) < 8) begin
               pos = $urandom_range(len - 5, 0);
               fb[pos]     = 8'h00;
               fb[pos + 1] = 8'h00;
               fb[pos + 2] = 8'h00;
               fb[pos + 3] = 8'h01;
               if ($urandom_range(3, 0) != 0) begin
                  nal_ty = 6'($urandom_range(15, 0));
                  if (nal_ty > 6'd9) nal_ty = nal_ty + 6'd6;
               end else begin
                  nal_ty = $urandom_range(1, 0) ? 6'($urandom_range(15, 10))
                                                : 6'($urandom_range(63, 22));
               end
               // the second header byte may fall past the end of the frame
               fb[pos + 4] = {1'($urandom_range(1, 0)), nal_ty, 1'($urandom_range(1, 0))};
            end
            send_frame(fb, $urandom_range(9, 0) != 0);
            repeat ($urandom_range(4, 0)) send_request(pick_len());
         end else if (choice < 85) begin
            repeat ($urandom_range(4, 1)) begin
               r.op             = hrfu_pkg::OP_FRAME_BYTE;
               r.byte_value     = ($urandom_range(1, 0) == 0) ? 8'h00
                                                              : 8'($urandom_range(255, 0));
               r.first_of_frame = ($urandom_range(7, 0) == 0);
               r.last_of_frame  = ($urandom_range(7, 0) == 0);
               r.payload_len    = 16'($urandom_range(65535, 0));
               send_item(r);
            end
         end else begin
            send_request(pick_len());
         end
      end
   endtask

   task automatic test_random_phases();
      program_limits(16'($urandom_range(300, 16)), 8'($urandom_range(255, 0)));
      run_traffic(60);
      program_limits(16'd16, 8'd0);
      run_traffic(40);
      program_limits(16'hFFFF, 8'd255);
      run_traffic(40);
      program_limits(16'($urandom_range(65535, 16)), 8'($urandom_range(255, 0)));
      run_traffic(40);
      program_limits(16'($urandom_range(2000, 16)), 8'($urandom_range(40, 0)));
      run_traffic(40);
   endtask

   // Long stretch with no gaps on either side.
   task automatic test_back_to_back();
      program_limits(hrfu_pkg::PACKET_SIZE_RESET, hrfu_pkg::HEADER_SIZE_RESET);
      req_gaps_on   = 1'b0;
      rsp_stalls_on = 1'b0;
      run_traffic(60);
      req_gaps_on   = 1'b1;
      rsp_stalls_on = 1'b1;
   endtask

   task automatic compare_field(input string name, input logic [15:0] want,
                                input logic [15:0] got);
      if (got !== want) begin
         if (mismatches < 10) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         end
         mismatches++;
      end
   endtask

   // Check every result transaction against the oldest owed result.
   always @(posedge clock) begin
      hrfu_pkg::hrfu_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (fu_results.size() == 0) begin
            if (mismatches < 10) begin
               $display("%0t: result transaction with none owed: %h", $time, rsp_data);
            end
            mismatches++;
         end else begin
            want = fu_results.pop_front();
            compare_field("kind", 16'(want.kind), 16'(rsp_data.kind));
            compare_field("scan_status", 16'(want.scan_status), 16'(rsp_data.scan_status));
            compare_field("nal_type", 16'(want.nal_type), 16'(rsp_data.nal_type));
            compare_field("payload_offset", want.payload_offset, rsp_data.payload_offset);
            compare_field("header_byte0", 16'(want.header_byte0), 16'(rsp_data.header_byte0));
            compare_field("header_byte1", 16'(want.header_byte1), 16'(rsp_data.header_byte1));
            compare_field("header_byte2", 16'(want.header_byte2), 16'(rsp_data.header_byte2));
            compare_field("header_length", 16'(want.header_length),
                          16'(rsp_data.header_length));
         end
      end
   end

   initial begin
      // hold reset, then release it on a falling edge
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      test_requests_before_match();
      test_short_frames();
      test_header_window();
      test_packet_limits();
      test_extreme_limits();
      test_random_phases();
      test_back_to_back();
      // wait out owed results, then leave time for anything stray
      drain();
      repeat (8) @(negedge clock);
      if (mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // Stop a hung run.
   initial begin
      #400_000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule
